[sv/gb3_pkg.sv]
`default_nettype none

package gb3_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;
   localparam int LINE_W     = 48;
   localparam int NSLOT      = 4;
   localparam int RES_CAP    = 8;
   localparam int FIFO_DEPTH = RES_CAP;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // result slots of one input pixel, in delivery order
   localparam logic [1:0] SLOT_UPLEFT = 2'd0;
   localparam logic [1:0] SLOT_UP     = 2'd1;
   localparam logic [1:0] SLOT_LEFT   = 2'd2;
   localparam logic [1:0] SLOT_HERE   = 2'd3;

   // window position of each slot's center pixel
   localparam logic [1:0] ROW_CENTER [NSLOT] = '{2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic [1:0] COL_CENTER [NSLOT] = '{2'd1, 2'd2, 2'd1, 2'd2};

   // [0] red, [1] green, [2] blue
   typedef logic [2:0][7:0] rgb_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_red;
      logic [7:0]       out_green;
      logic [7:0]       out_blue;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             frame_last;
   } rsp_type;

   typedef logic [2:0][1:0] tap_w_type;

   typedef struct packed {
      tap_w_type [NSLOT-1:0] row_w;
      tap_w_type [NSLOT-1:0] col_w;
   } wts_type;

   typedef struct packed {
      logic [NSLOT-1:0]    emit;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      rgb_type [NSLOT-1:0] pix;
   } grp_type;

   // 1-2-1 weights along one axis, zero where the tap is out of frame or window
   function automatic tap_w_type tap_weights(input logic [1:0] center, input logic [2:0] ok);
      tap_w_type w;
      int        ci;
      ci = int'(center);
      for (int i = 0; i < 3; i++) begin
         if (!ok[i]) begin
            w[i] = 2'd0;
         end else if (i == ci) begin
            w[i] = 2'd2;
         end else if (i + 1 == ci || i == ci + 1) begin
            w[i] = 2'd1;
         end else begin
            w[i] = 2'd0;
         end
      end
      return w;
   endfunction

   function automatic logic [2:0] weight_sum(input tap_w_type w);
      return 3'(w[0]) + 3'(w[1]) + 3'(w[2]);
   endfunction

   // ceil(2^16 / weight); exact floor for sums below 4096
   function automatic logic [14:0] recip(input logic [4:0] weight);
      logic [14:0] r;
      unique case (weight)
         5'd4:    r = 15'd16384;
         5'd6:    r = 15'd10923;
         5'd8:    r = 15'd8192;
         5'd9:    r = 15'd7282;
         5'd12:   r = 15'd5462;
         5'd16:   r = 15'd4096;
         default: r = 15'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/gb3_linebuf.sv]
`default_nettype none

module gb3_linebuf (
   input  wire logic                         clock,
   input  wire logic                         rd_en,
   input  wire logic [gb3_pkg::COL_W-1:0]    rd_addr,
   output logic      [gb3_pkg::LINE_W-1:0]   rd_data,
   input  wire logic                         wr_en,
   input  wire logic [gb3_pkg::COL_W-1:0]    wr_addr,
   input  wire logic [gb3_pkg::LINE_W-1:0]   wr_data
);

   logic [gb3_pkg::LINE_W-1:0] mem [gb3_pkg::MAX_WIDTH];
   logic [gb3_pkg::LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/gb3_lane.sv]
`default_nettype none

module gb3_lane (
   input  wire logic                                clock,
   input  wire logic [2:0][2:0][7:0]                win,
   input  wire gb3_pkg::wts_type                    wts,
   output logic      [gb3_pkg::NSLOT-1:0][7:0]      quot
);

   logic [gb3_pkg::NSLOT-1:0][2:0][9:0] rowp;
   logic [gb3_pkg::NSLOT-1:0][11:0]     sum_in;
   logic [gb3_pkg::NSLOT-1:0][11:0]     sum_ff;
   logic [gb3_pkg::NSLOT-1:0][14:0]     recip_in;
   logic [gb3_pkg::NSLOT-1:0][14:0]     recip_ff;
   logic [gb3_pkg::NSLOT-1:0][26:0]     prod;
   logic [gb3_pkg::NSLOT-1:0][7:0]      quot_in;
   logic [gb3_pkg::NSLOT-1:0][7:0]      quot_ff;

   function automatic logic [11:0] scale(input logic [9:0] v, input logic [1:0] w);
      logic [11:0] r;
      unique case (w)
         2'd0:    r = 12'd0;
         2'd1:    r = {2'b00, v};
         2'd2:    r = {1'b0, v, 1'b0};
         default: r = 12'd0;
      endcase
      return r;
   endfunction

   always_comb begin
      for (int k = 0; k < gb3_pkg::NSLOT; k++) begin
         for (int r = 0; r < 3; r++) begin
            rowp[k][r] = 10'(scale({2'b00, win[r][0]}, wts.col_w[k][0])
                           + scale({2'b00, win[r][1]}, wts.col_w[k][1])
                           + scale({2'b00, win[r][2]}, wts.col_w[k][2]));
         end
         sum_in[k] = scale(rowp[k][0], wts.row_w[k][0])
                   + scale(rowp[k][1], wts.row_w[k][1])
                   + scale(rowp[k][2], wts.row_w[k][2]);
         recip_in[k] = gb3_pkg::recip(5'({2'b00, gb3_pkg::weight_sum(wts.row_w[k])}
                                        * {2'b00, gb3_pkg::weight_sum(wts.col_w[k])}));
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      recip_ff <= recip_in;
   end

   always_comb begin
      for (int k = 0; k < gb3_pkg::NSLOT; k++) begin
         prod[k]    = 27'(sum_ff[k]) * 27'(recip_ff[k]);
         quot_in[k] = prod[k][23:16];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

[sv/gb3_merge.sv]
`default_nettype none

module gb3_merge (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gb3_pkg::grp_type  grp,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output gb3_pkg::rsp_type       rsp_data
);

   gb3_pkg::grp_type                 fifo_ff [gb3_pkg::FIFO_DEPTH];
   logic [gb3_pkg::PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [gb3_pkg::PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [gb3_pkg::PTR_W:0]          count_ff, count_in;
   logic [gb3_pkg::NSLOT-1:0]        done_ff, done_in;
   logic                             valid_ff, valid_in;
   gb3_pkg::rsp_type                 data_ff, data_in;

   gb3_pkg::grp_type                 head;
   logic [gb3_pkg::NSLOT-1:0]        rem;
   logic [gb3_pkg::NSLOT-1:0]        pick;
   logic [1:0]                       slot;
   logic                             load;
   logic                             pop;
   gb3_pkg::rgb_type                 pix;

   assign head = fifo_ff[rd_ptr_ff];
   assign rem  = head.emit & ~done_ff;

   always_comb begin
      priority if (rem[gb3_pkg::SLOT_UPLEFT]) begin
         slot = gb3_pkg::SLOT_UPLEFT;
      end else if (rem[gb3_pkg::SLOT_UP]) begin
         slot = gb3_pkg::SLOT_UP;
      end else if (rem[gb3_pkg::SLOT_LEFT]) begin
         slot = gb3_pkg::SLOT_LEFT;
      end else begin
         slot = gb3_pkg::SLOT_HERE;
      end
   end

   assign pick = gb3_pkg::NSLOT'(1) << slot;
   assign load = (count_ff != '0) && (!valid_ff || !rsp_stall);
   assign pop  = load && ((rem & ~pick) == '0);
   assign pix  = head.pix[slot];

   always_comb begin
      data_in            = data_ff;
      valid_in           = valid_ff && rsp_stall;
      done_in            = done_ff;
      if (load) begin
         valid_in           = 1'b1;
         data_in.out_red    = pix[0];
         data_in.out_green  = pix[1];
         data_in.out_blue   = pix[2];
         data_in.out_row    = (slot == gb3_pkg::SLOT_UPLEFT || slot == gb3_pkg::SLOT_UP)
                              ? head.row - gb3_pkg::ROW_W'(1) : head.row;
         data_in.out_col    = (slot == gb3_pkg::SLOT_UPLEFT || slot == gb3_pkg::SLOT_LEFT)
                              ? head.col - gb3_pkg::COL_W'(1) : head.col;
         data_in.frame_last = (slot == gb3_pkg::SLOT_HERE);
         done_in            = pop ? '0 : (done_ff | pick);
      end
   end

   assign wr_ptr_in = push ? wr_ptr_ff + gb3_pkg::PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + gb3_pkg::PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + (gb3_pkg::PTR_W+1)'(push) - (gb3_pkg::PTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= grp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         done_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         done_ff   <= done_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

[sv/gaussian_blur_3x3_rgb_top.sv]
// The first result of a pixel passes s1, s2, s3, s4, the result queue and the rsp_data register.
// Throughput: one pixel per cycle while each pixel gives at most one result and rsp_stall is low;
// the result port moves one result per cycle when not stalled, so last-column and last-row pixels
// (two results, four on the final frame pixel) can hold input, bounded by an 8-result queue.
// Reset: synchronous; position, pipeline and queue cleared, width 640, height 480.
// Line buffers are not cleared.
`default_nettype none

module gaussian_blur_3x3_rgb_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire gb3_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output gb3_pkg::rsp_type       rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   localparam int COL_W = gb3_pkg::COL_W;
   localparam int ROW_W = gb3_pkg::ROW_W;
   localparam int NSLOT = gb3_pkg::NSLOT;

   logic [gb3_pkg::CFG_WIDTH_W-1:0]  width_ff, width_in;
   logic [gb3_pkg::CFG_HEIGHT_W-1:0] height_ff, height_in;
   logic [gb3_pkg::CFG_WIDTH_W-1:0]  w_eff;
   logic [gb3_pkg::CFG_HEIGHT_W-1:0] h_eff;
   logic                             csr_write;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              last_col, last_row;
   logic [NSLOT-1:0]  emit_now;
   logic [2:0]        n_now;
   logic [3:0]        res_ff, res_in;
   logic              accept;
   logic              rsp_xfer;
   gb3_pkg::rgb_type  pix_now;

   logic              s1_valid_ff;
   logic [NSLOT-1:0]  s1_emit_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   gb3_pkg::rgb_type  s1_pix_ff;

   logic [gb3_pkg::LINE_W-1:0] rd_data;
   logic [gb3_pkg::LINE_W-1:0] line_word;
   logic [gb3_pkg::LINE_W-1:0] wr_data;
   gb3_pkg::rgb_type           line_older, line_newer;
   logic                       bp_valid_ff;
   logic [COL_W-1:0]           bp_addr_ff;
   logic [gb3_pkg::LINE_W-1:0] bp_data_ff;

   gb3_pkg::rgb_type [2:0][2:0] win_ff, win_in;
   logic [2:0]                  row_ok, col_ok;
   gb3_pkg::wts_type            wts_in;

   logic              s2_valid_ff;
   logic [NSLOT-1:0]  s2_emit_ff;
   logic [ROW_W-1:0]  s2_row_ff;
   logic [COL_W-1:0]  s2_col_ff;
   gb3_pkg::wts_type  s2_wts_ff;

   logic              s3_valid_ff;
   logic [NSLOT-1:0]  s3_emit_ff;
   logic [ROW_W-1:0]  s3_row_ff;
   logic [COL_W-1:0]  s3_col_ff;

   logic              s4_valid_ff;
   logic [NSLOT-1:0]  s4_emit_ff;
   logic [ROW_W-1:0]  s4_row_ff;
   logic [COL_W-1:0]  s4_col_ff;

   logic [2:0][2:0][2:0][7:0]  lane_win;
   logic [2:0][NSLOT-1:0][7:0] lane_q;
   gb3_pkg::grp_type           grp;
   logic                       push;

   // configuration
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (paddr[2])
            gb3_pkg::REG_WIDTH:  width_in  = pwdata[gb3_pkg::CFG_WIDTH_W-1:0];
            gb3_pkg::REG_HEIGHT: height_in = pwdata[gb3_pkg::CFG_HEIGHT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         gb3_pkg::REG_WIDTH:  prdata = 32'(width_ff);
         gb3_pkg::REG_HEIGHT: prdata = 32'(height_ff);
      endcase
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = gb3_pkg::CFG_WIDTH_W'(1);
      end else if (width_ff > gb3_pkg::CFG_WIDTH_W'(gb3_pkg::MAX_WIDTH)) begin
         w_eff = gb3_pkg::CFG_WIDTH_W'(gb3_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = gb3_pkg::CFG_HEIGHT_W'(1);
      end else if (height_ff > gb3_pkg::CFG_HEIGHT_W'(gb3_pkg::MAX_HEIGHT)) begin
         h_eff = gb3_pkg::CFG_HEIGHT_W'(gb3_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // position and result reservation
   assign last_col = (gb3_pkg::CFG_WIDTH_W'(col_ff) == w_eff - gb3_pkg::CFG_WIDTH_W'(1));
   assign last_row = (gb3_pkg::CFG_HEIGHT_W'(row_ff) == h_eff - gb3_pkg::CFG_HEIGHT_W'(1));

   assign emit_now[gb3_pkg::SLOT_UPLEFT] = (row_ff != '0) && (col_ff != '0);
   assign emit_now[gb3_pkg::SLOT_UP]     = (row_ff != '0) && last_col;
   assign emit_now[gb3_pkg::SLOT_LEFT]   = last_row && (col_ff != '0);
   assign emit_now[gb3_pkg::SLOT_HERE]   = last_row && last_col;
   assign n_now = 3'(emit_now[0]) + 3'(emit_now[1]) + 3'(emit_now[2]) + 3'(emit_now[3]);

   assign req_stall = (5'(res_ff) + 5'(n_now)) > 5'(gb3_pkg::RES_CAP);
   assign accept    = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign res_in    = res_ff + (accept ? 4'(n_now) : 4'd0) - (rsp_xfer ? 4'd1 : 4'd0);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign pix_now = {req_data.in_blue, req_data.in_green, req_data.in_red};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= gb3_pkg::CFG_WIDTH_W'(640);
         height_ff   <= gb3_pkg::CFG_HEIGHT_W'(480);
         col_ff      <= '0;
         row_ff      <= '0;
         res_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         bp_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         res_ff      <= res_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         bp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= emit_now;
         s1_row_ff  <= row_ff;
         s1_col_ff  <= col_ff;
         s1_pix_ff  <= pix_now;
      end
   end

   // line buffers: [47:24] two rows up, [23:0] one row up
   gb3_linebuf u_linebuf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data)
   );

   // single-column frames read the entry written in the same cycle
   assign line_word  = (bp_valid_ff && bp_addr_ff == s1_col_ff) ? bp_data_ff : rd_data;
   assign line_older = line_word[47:24];
   assign line_newer = line_word[23:0];
   assign wr_data    = {line_newer, s1_pix_ff};

   always_ff @(posedge clock) begin
      bp_addr_ff <= s1_col_ff;
      bp_data_ff <= wr_data;
   end

   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = line_older;
         win_in[1][2] = line_newer;
         win_in[2][2] = s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   // tap weights per slot from frame borders
   assign row_ok = {1'b1, s1_row_ff != '0, s1_row_ff > ROW_W'(1)};
   assign col_ok = {1'b1, s1_col_ff != '0, s1_col_ff > COL_W'(1)};

   always_comb begin
      for (int k = 0; k < NSLOT; k++) begin
         wts_in.row_w[k] = gb3_pkg::tap_weights(gb3_pkg::ROW_CENTER[k], row_ok);
         wts_in.col_w[k] = gb3_pkg::tap_weights(gb3_pkg::COL_CENTER[k], col_ok);
      end
   end

   always_ff @(posedge clock) begin
      s2_emit_ff <= s1_emit_ff;
      s2_row_ff  <= s1_row_ff;
      s2_col_ff  <= s1_col_ff;
      s2_wts_ff  <= wts_in;
      s3_emit_ff <= s2_emit_ff;
      s3_row_ff  <= s2_row_ff;
      s3_col_ff  <= s2_col_ff;
      s4_emit_ff <= s3_emit_ff;
      s4_row_ff  <= s3_row_ff;
      s4_col_ff  <= s3_col_ff;
   end

   // one lane per color channel
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               lane_win[ch][r][c] = win_ff[r][c][ch];
            end
         end
      end
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_lane
      gb3_lane u_lane (
         .clock (clock),
         .win   (lane_win[ch]),
         .wts   (s2_wts_ff),
         .quot  (lane_q[ch])
      );
   end

   always_comb begin
      grp.emit = s4_emit_ff;
      grp.row  = s4_row_ff;
      grp.col  = s4_col_ff;
      for (int k = 0; k < NSLOT; k++) begin
         for (int ch = 0; ch < 3; ch++) begin
            grp.pix[k][ch] = lane_q[ch][k];
         end
      end
   end

   assign push = s4_valid_ff && (s4_emit_ff != '0);

   gb3_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .grp       (grp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[tb/sv/gaussian_blur_3x3_rgb_top_tb.sv]
module gaussian_blur_3x3_rgb_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 16;

   class blur_scoreboard;
      logic [23:0] older_row [gb3_pkg::MAX_WIDTH];
      logic [23:0] newer_row [gb3_pkg::MAX_WIDTH];
      logic [23:0] win [3][3];
      int unsigned width_reg;
      int unsigned height_reg;
      int row_pos;
      int col_pos;
      gb3_pkg::rsp_type pending_pixels [$];
      int errors;

      function new();
         foreach (older_row[i]) begin
            older_row[i] = '0;
            newer_row[i] = '0;
         end
         foreach (win[i, j]) win[i][j] = '0;
         width_reg = 640;
         height_reg = 480;
         row_pos = 0;
         col_pos = 0;
         errors = 0;
      endfunction

      function void write_reg(logic index, logic [31:0] value);
         if (index == gb3_pkg::REG_WIDTH) begin
            width_reg = value & 32'hFFF;
         end else begin
            height_reg = value & 32'h1FFF;
         end
         row_pos = 0;
         col_pos = 0;
      endfunction

      function int active_width();
         if (width_reg == 0) return 1;
         if (width_reg > gb3_pkg::MAX_WIDTH) return gb3_pkg::MAX_WIDTH;
         return int'(width_reg);
      endfunction

      function int active_height();
         if (height_reg == 0) return 1;
         if (height_reg > gb3_pkg::MAX_HEIGHT) return gb3_pkg::MAX_HEIGHT;
         return int'(height_reg);
      endfunction

      // (cy, cx) is blurred; the newest window entry is pixel (r, c)
      function gb3_pkg::rsp_type blur_at(int cy, int cx, int r, int c, int w, int h, bit last);
         int sum [3];
         int weight;
         int y, x, wr, wc, k, ady, adx;
         gb3_pkg::rsp_type o;
         sum = '{0, 0, 0};
         weight = 0;
         for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
               y = cy + dy;
               x = cx + dx;
               wr = y - (r - 2);
               wc = x - (c - 2);
               if (y < 0 || y >= h || x < 0 || x >= w) continue;
               if (wr < 0 || wr > 2 || wc < 0 || wc > 2) continue;
               ady = (dy < 0) ? -dy : dy;
               adx = (dx < 0) ? -dx : dx;
               k = (2 - ady) * (2 - adx);
               for (int ch = 0; ch < 3; ch++) sum[ch] += int'(win[wr][wc][8*ch +: 8]) * k;
               weight += k;
            end
         end
         o.out_red = 8'(sum[0] / weight);
         o.out_green = 8'(sum[1] / weight);
         o.out_blue = 8'(sum[2] / weight);
         o.out_row = 12'(cy);
         o.out_col = 11'(cx);
         o.frame_last = last;
         return o;
      endfunction

      function void note_pixel(gb3_pkg::req_type p);
         int w, h, r, c;
         logic [23:0] pix;
         w = active_width();
         h = active_height();
         if (col_pos >= w) col_pos = 0;
         if (row_pos >= h) row_pos = 0;
         r = row_pos;
         c = col_pos;
         pix = {p.in_blue, p.in_green, p.in_red};
         for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
         end
         win[0][2] = older_row[c];
         win[1][2] = newer_row[c];
         win[2][2] = pix;
         older_row[c] = newer_row[c];
         newer_row[c] = pix;
         if (r >= 1) begin
            if (c >= 1) pending_pixels.push_back(blur_at(r - 1, c - 1, r, c, w, h, 1'b0));
            if (c == w - 1) pending_pixels.push_back(blur_at(r - 1, c, r, c, w, h, 1'b0));
         end
         if (r == h - 1) begin
            if (c >= 1) pending_pixels.push_back(blur_at(r, c - 1, r, c, w, h, 1'b0));
            if (c == w - 1) pending_pixels.push_back(blur_at(r, c, r, c, w, h, 1'b1));
         end
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      function void check_pixel(gb3_pkg::rsp_type got);
         gb3_pkg::rsp_type want;
         string diff;
         if (pending_pixels.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: rgb %02h %02h %02h row %0d col %0d last %0d",
                        got.out_red, got.out_green, got.out_blue,
                        got.out_row, got.out_col, got.frame_last);
            return;
         end
         want = pending_pixels.pop_front();
         diff = "";
         if (got.out_red !== want.out_red) diff = {diff, " red"};
         if (got.out_green !== want.out_green) diff = {diff, " green"};
         if (got.out_blue !== want.out_blue) diff = {diff, " blue"};
         if (got.out_row !== want.out_row) diff = {diff, " row"};
         if (got.out_col !== want.out_col) diff = {diff, " col"};
         if (got.frame_last !== want.frame_last) diff = {diff, " last"};
         if (diff != "") begin
            errors++;
            if (errors <= 10) begin
               $write("mismatch in%s: expected rgb %02h %02h %02h row %0d col %0d last %0d,",
                      diff, want.out_red, want.out_green, want.out_blue,
                      want.out_row, want.out_col, want.frame_last);
               $display(" got rgb %02h %02h %02h row %0d col %0d last %0d",
                        got.out_red, got.out_green, got.out_blue,
                        got.out_row, got.out_col, got.frame_last);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   gb3_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   gb3_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   blur_scoreboard sb;
   int send_gap_pct = 0;
   int rsp_hold_pct = 0;
   int cycle_count = 0;

   gaussian_blur_3x3_rgb_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_pixel(rsp_data);
   end

   // entered and left at a falling edge
   task automatic csr_write(input logic index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(index, value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input int w, input int h);
      csr_write(gb3_pkg::REG_WIDTH, 32'(w));
      csr_write(gb3_pkg::REG_HEIGHT, 32'(h));
   endtask

   task automatic send_pixel(input gb3_pkg::req_type p);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(p);
      @(negedge clock);
   endtask

   // wait out queued results and any pixel still in flight
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] random_level();
      if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
      return 8'($urandom);
   endfunction

   function automatic gb3_pkg::req_type random_pixel();
      gb3_pkg::req_type p;
      p.in_red = random_level();
      p.in_green = random_level();
      p.in_blue = random_level();
      return p;
   endfunction

   initial begin
      logic [7:0] levels [9];
      int w, h, n, sent;
      levels = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'h0F, 8'hF0, 8'h81};
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_gap_pct = 37;
      rsp_hold_pct = 46;

      // corners, edges and center of a 3x3 frame
      configure(3, 3);
      for (int i = 0; i < 9; i++)
         send_pixel(gb3_pkg::req_type'{levels[i], ~levels[i], levels[(i + 3) % 9]});
      drain();
      configure(1, 1);
      send_pixel(gb3_pkg::req_type'{8'hFF, 8'h80, 8'h01});
      drain();
      // zero width acts as one column
      configure(0, 3);
      send_pixel(gb3_pkg::req_type'{8'h00, 8'hFF, 8'h7F});
      send_pixel(gb3_pkg::req_type'{8'hFF, 8'h00, 8'hFE});
      send_pixel(gb3_pkg::req_type'{8'h5A, 8'hA5, 8'h3C});
      drain();
      // oversize width clamps, zero height acts as one row
      configure(4095, 0);
      repeat (6) send_pixel(random_pixel());
      drain();
      configure(1, 8191);
      repeat (4) send_pixel(random_pixel());
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct = (phase == 0) ? 37 : (phase == 1) ? 46 : 0;
         rsp_hold_pct = (phase == 0) ? 46 : (phase == 1) ? 37 : 0;
         sent = 0;
         while (sent < 100) begin
            if ($urandom_range(9) == 0) begin
               case ($urandom_range(3))
                  0: begin
                     w = gb3_pkg::MAX_WIDTH;
                     h = 1;
                     n = $urandom_range(16, 40);
                  end
                  1: begin w = 4095; h = 0; n = $urandom_range(8, 24); end
                  2: begin
                     w = $urandom_range(1, 3);
                     h = gb3_pkg::MAX_HEIGHT;
                     n = $urandom_range(10, 30);
                  end
                  default: begin w = 0; h = 8191; n = $urandom_range(10, 20); end
               endcase
            end else begin
               w = $urandom_range(1, 8);
               h = $urandom_range(1, 5);
               n = w * h * $urandom_range(1, 2);
               if ($urandom_range(5) == 0) n = $urandom_range(1, w * h);
            end
            if (n > 100 - sent) n = 100 - sent;
            configure(w, h);
            repeat (n) send_pixel(random_pixel());
            sent += n;
            drain();
         end
      end

      if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[gaussian_blur_3x3_rgb_top.f]
sv/gb3_pkg.sv
sv/gb3_linebuf.sv
sv/gb3_lane.sv
sv/gb3_merge.sv
sv/gaussian_blur_3x3_rgb_top.sv
tb/sv/gaussian_blur_3x3_rgb_top_tb.sv
